// ===== rtl/htb_pkg.sv =====
package htb_pkg;
  localparam int SYMBOLS_DEF = 256;
  localparam int WEIGHT_W    = 24;

  typedef enum logic [1:0] {
    KIND_READY  = 2'd0,
    KIND_SYMBOL = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_MERGE,
    ST_RESP,
    ST_WALK,
    ST_WREAD,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_STORE,
    CMD_INIT,
    CMD_SCAN,
    CMD_MERGE,
    CMD_WALK,
    CMD_CLEAR,
    CMD_STEP
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic scan_first;
  } ctrl_t;

  typedef struct packed {
    logic       scan_done;
    logic       merge_done;
    logic       empty;
    logic       is_leaf;
    logic [7:0] sym;
  } stat_t;
endpackage

// ===== rtl/htb_datapath.sv =====
module htb_datapath #(
  parameter int SYMBOLS = htb_pkg::SYMBOLS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  htb_pkg::ctrl_t ctrl_i,
  input  logic [7:0]    symbol_i,
  input  logic [15:0]   count_i,
  input  logic          code_bit_i,
  output htb_pkg::stat_t stat_o
);
  import htb_pkg::*;
  localparam int NODES = 2 * SYMBOLS - 1;
  localparam int NW = $clog2(NODES);
  localparam int SW = $clog2(SYMBOLS);

  // leaves sit at their symbol index, internal nodes from SYMBOLS up
  logic [WEIGHT_W-1:0] weight_q [NODES];
  logic [NW-1:0] left_q [NODES];
  logic [NW-1:0] right_q [NODES];
  logic [NODES-1:0] live_q;
  logic [SYMBOLS-1:0] loaded_q;

  logic [NW-1:0] idx_q, best_q, first_q, next_q, root_q, pos_q, rd_idx_q;
  logic [WEIGHT_W-1:0] best_w_q, first_w_q, rd_w_q;
  logic [7:0] best_s_q, rd_s_q;
  logic best_v_q, have_first_q, rd_live_q;
  logic [NW-1:0] nint_q;
  logic [NW:0] nlive_q;

  // candidate precedes best: lower weight, lower symbol, then higher index
  logic better, take;
  always_comb begin
    if (rd_w_q != best_w_q) better = rd_w_q < best_w_q;
    else if (rd_s_q != best_s_q) better = rd_s_q < best_s_q;
    else better = rd_idx_q > best_q;
  end
  assign take = rd_live_q && (!best_v_q || better);

  logic [NW-1:0] new_idx, only_idx;
  assign new_idx = NW'(SYMBOLS) + nint_q;
  always_comb begin
    only_idx = '0;
    for (int s = 0; s < SYMBOLS; s++) if (loaded_q[s]) only_idx = NW'(s);
  end

  logic root_leaf, next_leaf, scan_end;
  assign root_leaf = 32'(root_q) < SYMBOLS;
  assign next_leaf = 32'(next_q) < SYMBOLS;
  assign scan_end = 32'(idx_q) == NODES;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0; loaded_q <= '0; idx_q <= '0; best_q <= '0; best_v_q <= 1'b0;
      have_first_q <= 1'b0; nint_q <= '0; nlive_q <= '0; root_q <= '0; pos_q <= '0;
      first_q <= '0; best_w_q <= '0; first_w_q <= '0; best_s_q <= '0;
      rd_live_q <= 1'b0; rd_idx_q <= '0; rd_s_q <= '0;
    end else begin
      case (ctrl_i.cmd)
        CMD_CLEAR: loaded_q <= '0;
        CMD_STORE: begin
          if (32'(symbol_i) < SYMBOLS) loaded_q[symbol_i[SW-1:0]] <= 1'b1;
        end
        CMD_INIT: begin
          live_q <= NODES'(loaded_q);
          nlive_q <= (NW+1)'($countones(loaded_q));
          nint_q <= '0; idx_q <= '0; best_v_q <= 1'b0; have_first_q <= 1'b0;
          rd_live_q <= 1'b0;
          root_q <= only_idx; pos_q <= only_idx;
        end
        CMD_SCAN: begin
          if (ctrl_i.scan_first) begin
            idx_q <= '0; best_v_q <= 1'b0; rd_live_q <= 1'b0;
          end else begin
            // compare runs one entry behind the table read
            if (take) begin
              best_q <= rd_idx_q; best_w_q <= rd_w_q; best_s_q <= rd_s_q;
              best_v_q <= 1'b1;
            end
            if (scan_end) begin
              rd_live_q <= 1'b0;
              live_q[take ? rd_idx_q : best_q] <= 1'b0;
              if (!have_first_q) begin
                first_q <= take ? rd_idx_q : best_q;
                first_w_q <= take ? rd_w_q : best_w_q;
                have_first_q <= 1'b1;
              end
            end else begin
              rd_live_q <= live_q[idx_q];
              rd_idx_q <= idx_q;
              rd_s_q <= (32'(idx_q) < SYMBOLS) ? 8'(idx_q) : 8'd0;
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        CMD_MERGE: begin
          live_q[new_idx] <= 1'b1;
          root_q <= new_idx; pos_q <= new_idx;
          nint_q <= nint_q + 1'b1;
          nlive_q <= nlive_q - 1'b1;
          have_first_q <= 1'b0;
        end
        CMD_STEP: begin
          if (!root_leaf) pos_q <= next_leaf ? root_q : next_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_STORE: begin
        if (32'(symbol_i) < SYMBOLS) begin
          weight_q[NW'(symbol_i)] <= WEIGHT_W'(count_i);
          left_q[NW'(symbol_i)] <= '0;
          right_q[NW'(symbol_i)] <= '0;
        end
      end
      CMD_SCAN: begin
        if (!ctrl_i.scan_first && !scan_end) rd_w_q <= weight_q[idx_q];
      end
      CMD_MERGE: begin
        weight_q[new_idx] <= WEIGHT_W'(first_w_q + best_w_q);
        left_q[new_idx] <= first_q;
        right_q[new_idx] <= best_q;
      end
      CMD_WALK: next_q <= code_bit_i ? right_q[pos_q] : left_q[pos_q];
      default: ;
    endcase
  end

  assign stat_o.scan_done = (ctrl_i.cmd == CMD_SCAN) && !ctrl_i.scan_first && scan_end;
  assign stat_o.merge_done = (nlive_q <= (NW+1)'(1));
  assign stat_o.empty = (loaded_q == '0);
  assign stat_o.is_leaf = root_leaf || next_leaf;
  assign stat_o.sym = root_leaf ? 8'(root_q) : 8'(next_q);
endmodule

// ===== rtl/htb_ctrl.sv =====
module htb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           mode_i,
  input  logic           last_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     sym_o,
  output htb_pkg::ctrl_t ctrl_o,
  input  htb_pkg::stat_t stat_i
);
  import htb_pkg::*;
  state_e st_q, st_d;
  logic ready_q, ready_d, half_q, half_d, ov_q, ov_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] sym_q, sym_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD; ready_q <= 1'b0; half_q <= 1'b0; ov_q <= 1'b0;
      kind_q <= '0; sym_q <= '0;
    end else begin
      st_q <= st_d; ready_q <= ready_d; half_q <= half_d; ov_q <= ov_d;
      kind_q <= kind_d; sym_q <= sym_d;
    end
  end

  logic acc;
  assign in_ready_o = (st_q == ST_LOAD) && !ov_q;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    st_d = st_q; ready_d = ready_q; half_d = half_q; ov_d = ov_q;
    kind_d = kind_q; sym_d = sym_q;
    ctrl_o = '{cmd: CMD_NONE, scan_first: 1'b0};
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      ST_LOAD: if (acc) begin
        if (!mode_i) begin
          if (ready_q) begin ctrl_o.cmd = CMD_CLEAR; ready_d = 1'b0; st_d = ST_RESP; end
          else begin
            ctrl_o.cmd = CMD_STORE;
            if (last_i) st_d = ST_INIT;
          end
        end else if (!ready_q) begin
          ov_d = 1'b1; kind_d = KIND_ERROR; sym_d = '0;
        end else begin
          ctrl_o.cmd = CMD_WALK; st_d = ST_WREAD;
        end
      end
      ST_RESP: begin  // store after clear, same beat held
        ctrl_o.cmd = CMD_STORE;
        st_d = last_i ? ST_INIT : ST_LOAD;
      end
      ST_INIT: begin
        if (stat_i.empty) begin
          ov_d = 1'b1; kind_d = KIND_ERROR; sym_d = '0; st_d = ST_LOAD;
        end else begin
          ctrl_o.cmd = CMD_INIT; half_d = 1'b0; st_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (stat_i.merge_done) begin
          ov_d = 1'b1; kind_d = KIND_READY; sym_d = '0; ready_d = 1'b1; st_d = ST_LOAD;
        end else begin
          ctrl_o.cmd = CMD_SCAN; ctrl_o.scan_first = 1'b1; st_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl_o.cmd = CMD_SCAN;
        if (stat_i.scan_done) begin
          if (half_q) begin half_d = 1'b0; st_d = ST_OUT; end
          else begin half_d = 1'b1; st_d = ST_MERGE; end
        end
      end
      ST_OUT: begin ctrl_o.cmd = CMD_MERGE; st_d = ST_MERGE; end
      ST_WREAD: begin
        ctrl_o.cmd = CMD_STEP;
        if (stat_i.is_leaf) begin ov_d = 1'b1; kind_d = KIND_SYMBOL; sym_d = stat_i.sym; end
        st_d = ST_LOAD;
      end
      default: st_d = ST_LOAD;
    endcase
    // second scan must not restart the pair state; merge re-entry handled by half flag
    if (st_q == ST_MERGE && half_q && !stat_i.merge_done) begin
      ctrl_o.cmd = CMD_SCAN; ctrl_o.scan_first = 1'b1; st_d = ST_SCAN;
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o = kind_q;
  assign sym_o = sym_q;
endmodule

// ===== rtl/huffman_tree_build_and_decode.sv =====
// channel  dir  tdata fields (low first)                  tuser
// s_axis   in   mode, symbol, count, code_bit (pad to 32)  -      tlast = last_entry
// m_axis   out  symbol_out                                 kind
// Entries are stored when accepted; an entry after a built tree first clears, then stores.
// Code bits do a node read, then a leaf check; one that reaches a leaf sends a result beat.
// Build: each merge takes two scans of the node table, then the merge step.
// Input is stalled while a build runs or a result waits.
// Reset clears the loaded marks and control; node tables are not cleared.
module huffman_tree_build_and_decode #(
  parameter int SYMBOLS = htb_pkg::SYMBOLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // mode, symbol, count, code_bit
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // symbol_out
  output logic [1:0]  m_axis_tuser    // kind
);
  import htb_pkg::*;
  ctrl_t ctrl;
  stat_t stat;
  logic [7:0] sym_q;
  logic [15:0] cnt_q;
  logic last_q;
  always_ff @(posedge clk_i) if (s_axis_tvalid && s_axis_tready) begin
    sym_q <= s_axis_tdata[8:1]; cnt_q <= s_axis_tdata[24:9]; last_q <= s_axis_tlast;
  end
  logic [7:0] sym_sel;
  logic [15:0] cnt_sel;
  logic last_sel;
  assign sym_sel = s_axis_tready ? s_axis_tdata[8:1] : sym_q;
  assign cnt_sel = s_axis_tready ? s_axis_tdata[24:9] : cnt_q;
  assign last_sel = s_axis_tready ? s_axis_tlast : last_q;

  htb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tdata[0]), .last_i(last_sel), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .kind_o(m_axis_tuser), .sym_o(m_axis_tdata),
    .ctrl_o(ctrl), .stat_i(stat)
  );
  htb_datapath #(.SYMBOLS(SYMBOLS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .symbol_i(sym_sel), .count_i(cnt_sel),
    .code_bit_i(s_axis_tdata[25]), .stat_o(stat)
  );

  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_sym_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_SYMBOL) |-> m_axis_tdata == 8'd0)
    else $error("symbol nonzero");
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import htb_pkg::*;

  localparam int NSYM  = 256;
  localparam int NNODE = 2 * NSYM - 1;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    bit         mode;
    bit [7:0]   sym;
    bit [15:0]  cnt;
    bit         last;
    bit         code;
    bit         drain;  // hold until all results are back
  } beat_t;

  typedef struct {
    kind_e    kind;
    bit [7:0] sym;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // mode, symbol, count, code_bit
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // symbol_out
  logic [1:0]  m_axis_tuser;        // kind

  huffman_tree_build_and_decode dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial forever #1 clk_i = ~clk_i;

  beat_t   pending_beats[$];
  result_t expected_results[$];
  int      mismatches = 0;
  longint  cycles = 0;

  // shadow copy of the node table
  logic [23:0] wt[NNODE];
  logic [8:0]  lch[NNODE], rch[NNODE];
  logic [7:0]  nsym[NNODE];
  bit          leaf[NNODE], live[NNODE];
  bit          loaded[NSYM];
  int          root, walk;
  bit          ready;

  function automatic void clear_tree();
    for (int i = 0; i < NNODE; i++) begin
      wt[i] = '0; lch[i] = '0; rch[i] = '0; nsym[i] = '0; leaf[i] = 0; live[i] = 0;
    end
    for (int s = 0; s < NSYM; s++) loaded[s] = 0;
    root = 0; walk = 0; ready = 0;
  endfunction

  function automatic bit goes_first(int a, int b);
    if (wt[a] != wt[b]) return wt[a] < wt[b];
    if (nsym[a] != nsym[b]) return nsym[a] < nsym[b];
    return a > b;
  endfunction

  function automatic int pop_lightest();
    int best;
    best = -1;
    for (int i = 0; i < NNODE; i++)
      if (live[i] && (best < 0 || goes_first(i, best))) best = i;
    if (best >= 0) live[best] = 0;
    return best;
  endfunction

  function automatic bit build_tree();
    int n, only, a, b, idx;
    n = 0; only = 0;
    for (int i = 0; i < NNODE; i++) live[i] = 0;
    for (int s = 0; s < NSYM; s++)
      if (loaded[s]) begin
        live[s] = 1; n++; only = s;
      end
    if (n == 0) return 0;
    if (n == 1) begin
      root = only;
    end else begin
      for (int k = 0; k + 1 < n; k++) begin
        a = pop_lightest();
        b = pop_lightest();
        idx = NSYM + k;
        wt[idx] = 24'(wt[a] + wt[b]);
        lch[idx] = 9'(a); rch[idx] = 9'(b);
        nsym[idx] = '0; leaf[idx] = 0; live[idx] = 1;
        root = idx;
      end
    end
    walk = root;
    ready = 1;
    return 1;
  endfunction

  function automatic void decode_step(beat_t bt);
    result_t r;
    int nxt;
    r.sym = '0;
    if (bt.mode == 1'b0) begin
      if (ready) clear_tree();
      wt[bt.sym] = 24'(bt.cnt); nsym[bt.sym] = bt.sym; leaf[bt.sym] = 1;
      lch[bt.sym] = '0; rch[bt.sym] = '0; loaded[bt.sym] = 1;
      if (!bt.last) return;
      if (build_tree()) r.kind = KIND_READY;
      else r.kind = KIND_ERROR;
      expected_results = {expected_results, r};
    end else if (!ready) begin
      r.kind = KIND_ERROR;
      expected_results = {expected_results, r};
    end else if (leaf[root]) begin
      r.kind = KIND_SYMBOL; r.sym = nsym[root];
      expected_results = {expected_results, r};
    end else begin
      nxt = bt.code ? rch[walk] : lch[walk];
      if (leaf[nxt]) begin
        walk = root;
        r.kind = KIND_SYMBOL; r.sym = nsym[nxt];
        expected_results = {expected_results, r};
      end else begin
        walk = nxt;
      end
    end
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  beat_t cur_beat;
  int    tx_gap = 0;
  bit    tx_burst = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) decode_step(cur_beat);
      if ($urandom_range(0, 99) == 0) tx_burst = ~tx_burst;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0 &&
                     !(pending_beats[0].drain && expected_results.size() > 0)) begin
          cur_beat = pending_beats.pop_front();
          s_axis_tdata <= {6'b0, cur_beat.code, cur_beat.cnt, cur_beat.sym, cur_beat.mode};
          s_axis_tlast <= cur_beat.last;
          s_axis_tvalid <= 1'b1;
          tx_gap = pick_gap(tx_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int  rx_gap = 0;
  bit  rx_burst = 0;
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: kind %0d sym %0d", m_axis_tuser, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser !== want.kind || m_axis_tdata !== want.sym) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected kind %0d sym %0d, got kind %0d sym %0d",
                       want.kind, want.sym, m_axis_tuser, m_axis_tdata);
          end
        end
      end
      if ($urandom_range(0, 99) == 0) rx_burst = ~rx_burst;
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap = pick_gap(rx_burst);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_entry(int sym, int cnt, bit last, bit drain = 0);
    beat_t b;
    b.mode = 0; b.sym = 8'(sym); b.cnt = 16'(cnt); b.last = last;
    b.code = 1'($urandom_range(0, 1)); b.drain = drain;
    pending_beats = {pending_beats, b};
  endtask

  task automatic add_bits(int n);
    beat_t b;
    for (int i = 0; i < n; i++) begin
      b.mode = 1; b.code = 1'($urandom_range(0, 1));
      b.sym = 8'($urandom_range(0, 255)); b.cnt = 16'($urandom_range(0, 65535));
      b.last = 1'($urandom_range(0, 1)); b.drain = 0;
      pending_beats = {pending_beats, b};
    end
  endtask

  initial begin
    int n, syms[$];
    bit ties;
    clear_tree();
    // code bit with no tree
    add_bits(1);
    // single symbol tree
    add_entry(255, 65535, 1);
    add_bits(3);
    // replaced count, zero counts, symbol ties
    add_entry(0, 0, 0);
    add_entry(7, 5, 0);
    add_entry(7, 1, 0);
    add_entry(200, 1, 0);
    add_entry(3, 0, 1);
    add_bits(8);
    // weights past 16 bits
    add_entry(10, 65535, 0, 1);
    add_entry(11, 65535, 0);
    add_entry(12, 65535, 1);
    add_bits(6);

    while (pending_beats.size() < 250) begin
      n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
      ties = 1'($urandom_range(0, 1));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) add_bits(1);
        add_entry($urandom_range(0, 255),
                  ties ? $urandom_range(0, 3) : $urandom_range(0, 65535),
                  i == n - 1, i == 0 && $urandom_range(0, 7) == 0);
      end
      add_bits($urandom_range(10, 40));
    end

    // full alphabet in shuffled order
    for (int s = 0; s < NSYM; s++) syms = {syms, s};
    syms.shuffle();
    for (int i = 0; i < NSYM; i++)
      add_entry(syms[i], $urandom_range(0, 65535), i == NSYM - 1);
    add_bits(40);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_beats.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
